// File: hdl/fra_pkg.sv
// Shared types, constants and helpers of the FIFO resource allocator.
package fra_pkg;

  // Wait queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int UNIT_W = 16;
  localparam int ID_W   = 16;
  localparam int SEC_W  = 32;
  localparam int CMD_W  = 2;
  localparam int KIND_W = 3;

  // Stream widths: tdata is padded up to whole bytes.
  localparam int IN_DATA_W  = ((3 * 16 + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * 16 + FILL_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 8'd1;
  localparam logic [UNIT_W-1:0]    TIMEOUT_RESET = 16'd30;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WAIT_GNT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WAIT_EXP = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STATUS   = 3'd5;

  // One queued request as stored in the queue memory.
  typedef struct packed {
    logic [SEC_W-1:0]  arrival;
    logic [UNIT_W-1:0] amount;
    logic [ID_W-1:0]   origin;
    logic [ID_W-1:0]   job;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   job;
    logic [ID_W-1:0]   origin;
    logic [UNIT_W-1:0] free_units;
    logic [FILL_W-1:0] waiting;
    logic              last;
  } result_t;

  // Circular pointer increment that also works for depths that are not powers of two.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

endpackage

// File: hdl/fra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/fra_out_reg.sv
// Output register of the result stream: holds one result until it is taken.
module fra_out_reg import fra_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t res_in,
  input  logic    out_tready,
  output logic    out_tvalid,
  output result_t res_q
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // A new result may be loaded when the slot is empty or being drained.
  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res_in;
    end
  end

  assign out_tvalid = valid_r;
  assign res_q      = res_r;

`ifndef SYNTHESIS
  // A stalled result must not be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!valid_r || out_tready))
    else $error("result overwritten while stalled");
`endif

endmodule

// File: hdl/fifo_resource_allocator_core.sv
// Top level of the FIFO resource allocator: control sequencer and queue state.
//
// Usage: the in_ channel carries one request per item: in_tuser selects reserve,
// release or tick, and in_tdata carries job, origin port and amount. Every
// request gives one or more results on the out_ channel; the final one of a
// request has out_tlast high. The cfg_ channel writes the capacity (which also
// reloads the free count) and the timeout; it is always ready, and the user must
// write it only while the block is idle; the block itself does not enforce this.
// Timing: a reserve is accepted, then decided and written to the queue in the command state.
// A release, a tick or an unused command passes the accept and command states; then the
// check state, where it applies, retires the waiters granted or expired one by one until a
// head stays queued or the queue empties, and the status state gives the final result.
// Requests are handled one at a time; the next is accepted as soon as the
// previous one has produced its last result, even while that result waits.
// Reset (rst_n low, synchronous) empties the queue, clears the seconds count,
// sets the free count to zero and the timeout to 30. There is no clearing pass.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds until the register can take the next one.
module fifo_resource_allocator_core import fra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // job_id[15:0], origin_port, amount
  input  logic [CMD_W-1:0]      in_tuser,   // command
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // job_id_out, origin_out, free_units,
                                            // waiting_count, zero pad
  output logic [KIND_W-1:0]     out_tuser,  // kind
  output logic                  out_tlast,  // last
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [UNIT_W-1:0]     cfg_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CMD    = 2'd1;
  localparam logic [1:0] S_CHECK  = 2'd2;
  localparam logic [1:0] S_STATUS = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ID_W-1:0]   job_r, job_nxt;
  logic [ID_W-1:0]   origin_r, origin_nxt;
  logic [UNIT_W-1:0] amount_r, amount_nxt;
  logic [UNIT_W-1:0] free_r, free_nxt;
  logic [UNIT_W-1:0] timeout_r, timeout_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;

  logic              can_emit;
  logic              push;
  result_t           res;
  result_t           res_q;
  logic              wr_en;
  entry_t            wr_entry;
  entry_t            head_entry;
  logic [UNIT_W:0]   rel_sum;
  logic [SEC_W-1:0]  waited;
  logic              head_hit;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign can_emit  = !out_tvalid || out_tready;

  // Saturating release sum and head test.
  assign rel_sum  = {1'b0, free_r} + {1'b0, amount_r};
  assign waited   = sec_r - head_entry.arrival;
  assign head_hit = (cmd_r == CMD_RELEASE) ? (free_r >= head_entry.amount)
                                           : (waited >= SEC_W'(timeout_r));

  // New queue entry comes from the latched request.
  always_comb begin
    wr_entry.job     = job_r;
    wr_entry.origin  = origin_r;
    wr_entry.amount  = amount_r;
    wr_entry.arrival = sec_r;
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    job_nxt     = job_r;
    origin_nxt  = origin_r;
    amount_nxt  = amount_r;
    free_nxt    = free_r;
    timeout_nxt = timeout_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    sec_nxt     = sec_r;
    wr_en       = 1'b0;
    push        = 1'b0;
    res.kind    = KIND_STATUS;
    res.job     = job_r;
    res.origin  = origin_r;
    res.last    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = in_tuser;
          job_nxt    = in_tdata[15:0];
          origin_nxt = in_tdata[31:16];
          amount_nxt = in_tdata[47:32];
          state_nxt  = S_CMD;
        end
      end

      S_CMD: begin
        case (cmd_r)
          CMD_RESERVE: begin
            if (can_emit) begin
              push     = 1'b1;
              res.last = 1'b1;
              if (fill_r == '0 && free_r >= amount_r) begin
                free_nxt = free_r - amount_r;
                res.kind = KIND_GRANTED;
              end else if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
                res.kind = KIND_REJECTED;
              end else begin
                wr_en    = 1'b1;
                tail_nxt = ptr_inc(tail_r);
                fill_nxt = fill_r + 1'b1;
                res.kind = KIND_QUEUED;
              end
              state_nxt = S_IDLE;
            end
          end
          CMD_RELEASE: begin
            if (amount_r != '0) begin
              free_nxt  = rel_sum[UNIT_W] ? {UNIT_W{1'b1}} : rel_sum[UNIT_W-1:0];
              state_nxt = (fill_r != '0) ? S_CHECK : S_STATUS;
            end else begin
              state_nxt = S_STATUS;
            end
          end
          CMD_TICK: begin
            sec_nxt   = sec_r + 1'b1;
            state_nxt = (fill_r != '0) ? S_CHECK : S_STATUS;
          end
          default: begin
            state_nxt = S_STATUS;
          end
        endcase
      end

      // The head entry is valid in this state; retire it when it fits or expired.
      S_CHECK: begin
        if (!head_hit) begin
          state_nxt = S_STATUS;
        end else if (can_emit) begin
          push       = 1'b1;
          res.job    = head_entry.job;
          res.origin = head_entry.origin;
          head_nxt   = ptr_inc(head_r);
          fill_nxt   = fill_r - 1'b1;
          if (cmd_r == CMD_RELEASE) begin
            free_nxt = free_r - head_entry.amount;
            res.kind = KIND_WAIT_GNT;
          end else begin
            res.kind = KIND_WAIT_EXP;
          end
          if (fill_r == FILL_W'(1)) begin
            state_nxt = S_STATUS;
          end
        end
      end

      S_STATUS: begin
        if (can_emit) begin
          push       = 1'b1;
          res.kind   = KIND_STATUS;
          res.job    = '0;
          res.origin = '0;
          res.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The user must write registers only while idle; the block itself does not enforce this.
    if (cfg_valid) begin
      if (cfg_index == CFG_CAPACITY) begin
        free_nxt = cfg_data;
      end else if (cfg_index == CFG_TIMEOUT) begin
        timeout_nxt = cfg_data;
      end
    end

    res.free_units = free_nxt;
    res.waiting    = fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      free_r    <= '0;
      timeout_r <= TIMEOUT_RESET;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      sec_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      free_r    <= free_nxt;
      timeout_r <= timeout_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
      sec_r     <= sec_nxt;
    end
  end

  // Latched request fields.
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    job_r    <= job_nxt;
    origin_r <= origin_nxt;
    amount_r <= amount_nxt;
  end

  // Queue memory; the read address follows the next head so the head is ready.
  fra_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_addr (head_nxt),
    .rd_data (head_entry)
  );

  fra_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res_in     (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_q      (res_q)
  );

  // Result stream packing.
  assign out_tdata = OUT_DATA_W'({res_q.waiting, res_q.free_units, res_q.origin, res_q.job});
  assign out_tuser = res_q.kind;
  assign out_tlast = res_q.last;

`ifndef SYNTHESIS
  // The queue never holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill exceeds depth");

  // The final result of a request returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.last) |=> (state_r == S_IDLE))
    else $error("sequencer not idle after final result");

  // Retiring a waiter removes exactly one entry.
  a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && push) |=> (fill_r == $past(fill_r) - 1'b1))
    else $error("waiter retired without queue pop");

  // The check state is only ever entered with a nonempty queue.
  a_check_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (fill_r != '0))
    else $error("queue head examined while queue empty");
`endif

endmodule
